@@ rtl/mie_pkg.sv @@
// Shared types and instruction codes for the MIPS I instruction executor
package mie_pkg;

	localparam int MEM_BYTES_DEF = 65536;

	// request kinds
	localparam logic [2:0] K_EXEC  = 3'd0;
	localparam logic [2:0] K_WRMEM = 3'd1;
	localparam logic [2:0] K_RDMEM = 3'd2;
	localparam logic [2:0] K_RDREG = 3'd3;
	localparam logic [2:0] K_SETPC = 3'd4;

	// special register indexes for register reads
	localparam logic [5:0] REG_HI = 6'd32;
	localparam logic [5:0] REG_LO = 6'd33;
	localparam logic [5:0] REG_PC = 6'd34;
	localparam logic [4:0] REG_SP = 5'd29;
	localparam logic [4:0] REG_RA = 5'd31;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// special function codes
	localparam logic [5:0] FN_SLL   = 6'h00;
	localparam logic [5:0] FN_SRL   = 6'h02;
	localparam logic [5:0] FN_SRA   = 6'h03;
	localparam logic [5:0] FN_SLLV  = 6'h04;
	localparam logic [5:0] FN_SRLV  = 6'h06;
	localparam logic [5:0] FN_SRAV  = 6'h07;
	localparam logic [5:0] FN_JR    = 6'h08;
	localparam logic [5:0] FN_JALR  = 6'h09;
	localparam logic [5:0] FN_MFHI  = 6'h10;
	localparam logic [5:0] FN_MTHI  = 6'h11;
	localparam logic [5:0] FN_MFLO  = 6'h12;
	localparam logic [5:0] FN_MTLO  = 6'h13;
	localparam logic [5:0] FN_MULT  = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV   = 6'h1A;
	localparam logic [5:0] FN_DIVU  = 6'h1B;
	localparam logic [5:0] FN_ADD   = 6'h20;
	localparam logic [5:0] FN_ADDU  = 6'h21;
	localparam logic [5:0] FN_SUB   = 6'h22;
	localparam logic [5:0] FN_SUBU  = 6'h23;
	localparam logic [5:0] FN_AND   = 6'h24;
	localparam logic [5:0] FN_OR    = 6'h25;
	localparam logic [5:0] FN_XOR   = 6'h26;
	localparam logic [5:0] FN_NOR   = 6'h27;
	localparam logic [5:0] FN_SLT   = 6'h2A;
	localparam logic [5:0] FN_SLTU  = 6'h2B;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr;
		logic cap_a;
		logic cap_b;
		logic exec;
		logic mem_step;
		logic fin;
	} mie_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic is_md;
		logic is_mem;
		logic md_done;
		logic mem_done;
		logic out_busy;
	} mie_sts_t;

	// multiply/divide operation select
	typedef struct packed {
		logic is_div;
		logic sgn;
	} mie_mdop_t;

endpackage

@@ rtl/mie_ram.sv @@
// Generic simple dual-port RAM with registered read
module mie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/mie_muldiv.sv @@
// Iterative multiply/divide unit, one bit per cycle
module mie_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mie_pkg::mie_mdop_t op,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic              done,
	output logic              upd,
	output logic [31:0]       hi,
	output logic [31:0]       lo
);
	import mie_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        upd_q;
	logic        div_q;
	logic        zero_q;
	logic        negq_q;
	logic        negr_q;
	logic [31:0] acc_q;
	logic [31:0] lo_q;
	logic [31:0] mb_q;
	logic [31:0] hi_res_q;
	logic [31:0] lo_res_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] mul_sum;
	logic [32:0] div_rs;
	logic [33:0] div_diff;
	logic [63:0] prod;
	logic [63:0] prod_n;

	// operand magnitudes
	assign ma = (op.sgn && a[31]) ? 32'd0 - a : a;
	assign mb = (op.sgn && b[31]) ? 32'd0 - b : b;

	// one step of shift-add multiply and restoring divide
	assign mul_sum  = {1'b0, acc_q} + (lo_q[0] ? {1'b0, mb_q} : 33'd0);
	assign div_rs   = {acc_q, lo_q[31]};
	assign div_diff = {1'b0, div_rs} - {2'b00, mb_q};
	assign prod     = {acc_q, lo_q};
	assign prod_n   = negq_q ? 64'd0 - prod : prod;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				if (cnt_q[5]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= 32'd0;
			lo_q   <= ma;
			mb_q   <= mb;
			div_q  <= op.is_div;
			zero_q <= op.is_div && (b == 32'd0);
			negq_q <= op.sgn && (a[31] ^ b[31]);
			negr_q <= op.sgn && a[31];
		end else if (busy_q && !cnt_q[5]) begin
			if (div_q) begin
				acc_q <= div_diff[33] ? div_rs[31:0] : div_diff[31:0];
				lo_q  <= {lo_q[30:0], ~div_diff[33]};
			end else begin
				acc_q <= mul_sum[32:1];
				lo_q  <= {mul_sum[0], lo_q[31:1]};
			end
		end else if (busy_q) begin
			upd_q <= !zero_q;
			if (div_q) begin
				lo_res_q <= negq_q ? 32'd0 - lo_q : lo_q;
				hi_res_q <= negr_q ? 32'd0 - acc_q : acc_q;
			end else begin
				lo_res_q <= prod_n[31:0];
				hi_res_q <= prod_n[63:32];
			end
		end
	end

	assign done = done_q;
	assign upd  = upd_q;
	assign hi   = hi_res_q;
	assign lo   = lo_res_q;

endmodule

@@ rtl/mie_datapath.sv @@
// Datapath: request registers, register file, ALU, byte memory and output register
module mie_datapath #(
	parameter int MEM_BYTES = mie_pkg::MEM_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mie_pkg::mie_cmd_t cmd,
	output mie_pkg::mie_sts_t sts,
	input  logic [2:0]       kind,
	input  logic [31:0]      instruction,
	input  logic [31:0]      address,
	input  logic [31:0]      data,
	input  logic [5:0]       reg_index,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [31:0]      read_data,
	output logic [31:0]      pc_after,
	output logic             unimplemented,
	output logic             halted
);
	import mie_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [31:0]   SP_RST   = 32'(MEM_BYTES - 4);
	localparam logic [32:0]   MEM_LIM  = 33'(MEM_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

	// request registers
	logic [2:0]  kind_q;
	logic [31:0] ins_q;
	logic [31:0] addr_q;
	logic [31:0] data_q;
	logic [5:0]  ri_q;

	// architectural state
	logic [31:0] pc_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] rf_vld_q;

	// operands and execute results
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] res_q;
	logic        rf_we_q;
	logic [4:0]  dst_q;
	logic [31:0] npc_q;
	logic        bad_q;

	// memory sequencing
	logic [2:0]    mem_cnt_q;
	logic [2:0]    mem_n_q;
	logic          mem_wr_q;
	logic          mem_ok_q;
	logic [31:0]   base_q;
	logic [31:0]   wsh_q;
	logic [23:0]   acc_q;
	logic [AW-1:0] clr_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_rdata_q;
	logic [31:0] out_pc_q;
	logic        out_bad_q;
	logic        out_halt_q;

	// decode
	logic [5:0]  op;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] ea;
	logic [31:0] btgt;
	logic [31:0] pc4;

	assign op   = ins_q[31:26];
	assign rt   = ins_q[20:16];
	assign rd   = ins_q[15:11];
	assign sh   = ins_q[10:6];
	assign fn   = ins_q[5:0];
	assign imm  = ins_q[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign ea   = a_q + simm;
	assign pc4  = pc_q + 32'd4;
	assign btgt = pc4 + {simm[29:0], 2'b00};

	// register file read
	logic [4:0]  rf_raddr;
	logic [4:0]  rf_idx_q;
	logic [31:0] rf_rdata;
	logic [31:0] rf_val;
	logic        rf_we;

	assign rf_raddr = cmd.load ? ((kind == K_RDREG) ? reg_index[4:0] : instruction[25:21]) : rt;
	assign rf_we    = cmd.fin && rf_we_q && (dst_q != 5'd0);

	// unwritten entries read as their reset value, register zero reads zero
	always_comb begin
		if (rf_idx_q == 5'd0) begin
			rf_val = 32'd0;
		end else if (rf_vld_q[rf_idx_q]) begin
			rf_val = rf_rdata;
		end else begin
			rf_val = (rf_idx_q == REG_SP) ? SP_RST : 32'd0;
		end
	end

	mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (dst_q),
		.wdata (res_q),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	// multiply/divide unit
	mie_mdop_t   md_op;
	logic        md_done;
	logic        md_upd;
	logic [31:0] md_hi;
	logic [31:0] md_lo;

	assign md_op.is_div = (fn == FN_DIV) || (fn == FN_DIVU);
	assign md_op.sgn    = (fn == FN_MULT) || (fn == FN_DIV);

	// execute decode
	logic [31:0] alu_res;
	logic        alu_we;
	logic [4:0]  alu_dst;
	logic [31:0] alu_npc;
	logic        alu_bad;
	logic        alu_mem;
	logic        alu_md;
	logic        m_wr;
	logic [2:0]  m_n;
	logic [31:0] m_base;
	logic [31:0] m_data;
	logic        hi_we;
	logic        lo_we;
	logic [31:0] m_wsh;
	logic        m_ok;

	always_comb begin
		alu_res = 32'd0;
		alu_we  = 1'b0;
		alu_dst = rt;
		alu_npc = pc_q;
		alu_bad = 1'b0;
		alu_mem = 1'b0;
		alu_md  = 1'b0;
		m_wr    = 1'b0;
		m_n     = 3'd4;
		m_base  = ea;
		m_data  = b_q;
		hi_we   = 1'b0;
		lo_we   = 1'b0;
		case (kind_q)
			K_EXEC: begin
				alu_npc = pc4;
				if (op == OP_SPECIAL) begin
					alu_dst = rd;
					alu_we  = 1'b1;
					case (fn)
						FN_SLL:  alu_res = b_q << sh;
						FN_SRL:  alu_res = b_q >> sh;
						FN_SRA:  alu_res = 32'($signed(b_q) >>> sh);
						FN_SLLV: alu_res = b_q << a_q[4:0];
						FN_SRLV: alu_res = b_q >> a_q[4:0];
						FN_SRAV: alu_res = 32'($signed(b_q) >>> a_q[4:0]);
						FN_JR: begin
							alu_we  = 1'b0;
							alu_npc = a_q;
						end
						FN_JALR: begin
							alu_res = pc_q + 32'd8;
							alu_npc = a_q;
						end
						FN_ADD, FN_ADDU: alu_res = a_q + b_q;
						FN_SUB, FN_SUBU: alu_res = a_q - b_q;
						FN_AND:  alu_res = a_q & b_q;
						FN_OR:   alu_res = a_q | b_q;
						FN_XOR:  alu_res = a_q ^ b_q;
						FN_NOR:  alu_res = ~(a_q | b_q);
						FN_SLT:  alu_res = {31'd0, $signed(a_q) < $signed(b_q)};
						FN_SLTU: alu_res = {31'd0, a_q < b_q};
						FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
							alu_we = 1'b0;
							alu_md = 1'b1;
						end
						FN_MFHI: alu_res = hi_q;
						FN_MFLO: alu_res = lo_q;
						FN_MTHI: begin
							alu_we = 1'b0;
							hi_we  = 1'b1;
						end
						FN_MTLO: begin
							alu_we = 1'b0;
							lo_we  = 1'b1;
						end
						default: begin
							alu_we  = 1'b0;
							alu_bad = 1'b1;
						end
					endcase
				end else if (op == OP_J || op == OP_JAL) begin
					alu_we  = (op == OP_JAL);
					alu_dst = REG_RA;
					alu_res = pc_q + 32'd8;
					alu_npc = {pc_q[31:28], ins_q[25:0], 2'b00};
				end else begin
					case (op)
						OP_ADDI, OP_ADDIU: begin
							alu_we  = 1'b1;
							alu_res = ea;
						end
						OP_ANDI: begin
							alu_we  = 1'b1;
							alu_res = a_q & {16'd0, imm};
						end
						OP_ORI: begin
							alu_we  = 1'b1;
							alu_res = a_q | {16'd0, imm};
						end
						OP_XORI: begin
							alu_we  = 1'b1;
							alu_res = a_q ^ {16'd0, imm};
						end
						OP_SLTI: begin
							alu_we  = 1'b1;
							alu_res = {31'd0, $signed(a_q) < $signed(simm)};
						end
						OP_SLTIU: begin
							alu_we  = 1'b1;
							alu_res = {31'd0, a_q < simm};
						end
						OP_LUI: begin
							alu_we  = 1'b1;
							alu_res = {imm, 16'd0};
						end
						OP_BEQ:  if (a_q == b_q) alu_npc = btgt;
						OP_BNE:  if (a_q != b_q) alu_npc = btgt;
						OP_BLEZ: if (a_q[31] || a_q == 32'd0) alu_npc = btgt;
						OP_BGTZ: if (!a_q[31] && a_q != 32'd0) alu_npc = btgt;
						OP_REGIMM: begin
							if ((rt == 5'd0 && a_q[31]) || (rt == 5'd1 && !a_q[31])) begin
								alu_npc = btgt;
							end
						end
						OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
							alu_we  = 1'b1;
							alu_mem = 1'b1;
							m_n     = (op == OP_LW) ? 3'd4 :
								((op == OP_LH || op == OP_LHU) ? 3'd2 : 3'd1);
						end
						OP_SW, OP_SH, OP_SB: begin
							alu_mem = 1'b1;
							m_wr    = 1'b1;
							m_n     = (op == OP_SW) ? 3'd4 : ((op == OP_SH) ? 3'd2 : 3'd1);
						end
						default: alu_bad = 1'b1;
					endcase
				end
			end
			K_WRMEM: begin
				alu_mem = 1'b1;
				m_wr    = 1'b1;
				m_base  = addr_q;
				m_data  = data_q;
			end
			K_RDMEM: begin
				alu_mem = 1'b1;
				m_base  = addr_q;
			end
			K_RDREG: begin
				if (!ri_q[5]) begin
					alu_res = a_q;
				end else if (ri_q == REG_HI) begin
					alu_res = hi_q;
				end else if (ri_q == REG_LO) begin
					alu_res = lo_q;
				end else if (ri_q == REG_PC) begin
					alu_res = pc_q;
				end
			end
			K_SETPC: alu_npc = data_q;
			default: alu_npc = pc_q;
		endcase
	end

	// store data aligned so the first byte sits on top; range check of the access
	assign m_wsh = (m_n == 3'd4) ? m_data :
		((m_n == 3'd2) ? {m_data[15:0], 16'd0} : {m_data[7:0], 24'd0});
	assign m_ok  = ({1'b0, m_base} + {30'd0, m_n} - 33'd1) < MEM_LIM;

	mie_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exec && alu_md),
		.op     (md_op),
		.a      (a_q),
		.b      (b_q),
		.done   (md_done),
		.upd    (md_upd),
		.hi     (md_hi),
		.lo     (md_lo)
	);

	// byte memory
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic [31:0]   mem_full;
	logic [31:0]   ld_val;

	assign mem_addr  = AW'(base_q + {29'd0, mem_cnt_q});
	assign mem_we    = cmd.clr ||
		(cmd.mem_step && mem_wr_q && mem_ok_q && (mem_cnt_q != mem_n_q));
	assign mem_waddr = cmd.clr ? clr_q : mem_addr;
	assign mem_wdata = cmd.clr ? 8'd0 : wsh_q[31:24];
	assign mem_full  = {acc_q, mem_rdata};

	mie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	// load extension
	always_comb begin
		if (!mem_ok_q) begin
			ld_val = 32'd0;
		end else if (kind_q != K_EXEC) begin
			ld_val = mem_full;
		end else begin
			case (op)
				OP_LH:   ld_val = {{16{mem_full[15]}}, mem_full[15:0]};
				OP_LHU:  ld_val = {16'd0, mem_full[15:0]};
				OP_LB:   ld_val = {{24{mem_full[7]}}, mem_full[7:0]};
				OP_LBU:  ld_val = {24'd0, mem_full[7:0]};
				default: ld_val = mem_full;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rf_idx_q <= rf_raddr;
		if (cmd.load) begin
			kind_q <= kind;
			ins_q  <= instruction;
			addr_q <= address;
			data_q <= data;
			ri_q   <= reg_index;
		end
		if (cmd.cap_a) begin
			a_q <= rf_val;
		end
		if (cmd.cap_b) begin
			b_q <= rf_val;
		end
		if (cmd.exec) begin
			res_q    <= alu_res;
			rf_we_q  <= alu_we;
			dst_q    <= alu_dst;
			npc_q    <= alu_npc;
			bad_q    <= alu_bad;
			mem_n_q  <= m_n;
			mem_wr_q <= m_wr;
			mem_ok_q <= m_ok;
			base_q   <= m_base;
			wsh_q    <= m_wsh;
		end
		if (cmd.mem_step) begin
			if (mem_wr_q) begin
				wsh_q <= {wsh_q[23:0], 8'd0};
			end else if (mem_cnt_q != 3'd0) begin
				acc_q <= mem_full[23:0];
			end
			if (mem_cnt_q == mem_n_q && !mem_wr_q) begin
				res_q <= ld_val;
			end
		end
		if (cmd.fin) begin
			out_rdata_q <= (kind_q == K_RDMEM || kind_q == K_RDREG) ? res_q : 32'd0;
			out_pc_q    <= npc_q;
			out_bad_q   <= bad_q;
			out_halt_q  <= (npc_q == 32'd0);
		end
	end

	// architectural and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= 32'd0;
			hi_q        <= 32'd0;
			lo_q        <= 32'd0;
			rf_vld_q    <= 32'd0;
			clr_q       <= '0;
			mem_cnt_q   <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.exec) begin
				mem_cnt_q <= 3'd0;
				if (hi_we) begin
					hi_q <= a_q;
				end
				if (lo_we) begin
					lo_q <= a_q;
				end
			end
			if (cmd.mem_step) begin
				mem_cnt_q <= mem_cnt_q + 3'd1;
			end
			if (md_done && md_upd) begin
				hi_q <= md_hi;
				lo_q <= md_lo;
			end
			if (rf_we) begin
				rf_vld_q[dst_q] <= 1'b1;
			end
			if (cmd.fin) begin
				pc_q        <= npc_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status to controller
	assign sts.clr_done = (clr_q == CLR_LAST);
	assign sts.is_md    = alu_md;
	assign sts.is_mem   = alu_mem;
	assign sts.md_done  = md_done;
	assign sts.mem_done = (mem_cnt_q == mem_n_q);
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid     = out_valid_q;
	assign read_data     = out_rdata_q;
	assign pc_after      = out_pc_q;
	assign unimplemented = out_bad_q;
	assign halted        = out_halt_q;

endmodule

@@ rtl/mie_ctrl.sv @@
// Controller state machine sequencing each request through the datapath
module mie_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mie_pkg::mie_sts_t sts,
	output mie_pkg::mie_cmd_t cmd
);
	import mie_pkg::*;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_OPA,
		S_OPB,
		S_EXE,
		S_MD,
		S_MEM,
		S_FIN
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			case (state_q)
				S_CLR:  if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_OPA;
				S_OPA:  state_q <= S_OPB;
				S_OPB:  state_q <= S_EXE;
				S_EXE: begin
					if (sts.is_md) begin
						state_q <= S_MD;
					end else if (sts.is_mem) begin
						state_q <= S_MEM;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MD:   if (sts.md_done) state_q <= S_FIN;
				S_MEM:  if (sts.mem_done) state_q <= S_FIN;
				S_FIN:  if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_CLR;
			endcase
		end
	end

	// commands decoded from state
	assign in_stall     = (state_q != S_IDLE);
	assign cmd.load     = (state_q == S_IDLE) && in_valid;
	assign cmd.clr      = (state_q == S_CLR);
	assign cmd.cap_a    = (state_q == S_OPA);
	assign cmd.cap_b    = (state_q == S_OPB);
	assign cmd.exec     = (state_q == S_EXE);
	assign cmd.mem_step = (state_q == S_MEM);
	assign cmd.fin      = (state_q == S_FIN) && !sts.out_busy;

endmodule

@@ rtl/mips1_instruction_executor_unit.sv @@
// MIPS I instruction executor top level: controller, datapath and port checks
//
// Each request executes one MIPS I instruction (no delay slots, no overflow traps)
// or does a side access: write or read a memory word, read a register, set pc.
// One result comes back per request. After reset the byte memory is cleared one
// byte per cycle, and in_stall stays high until the whole memory is clear and
// the first request can be taken. Requests are handled one at a time: each passes
// through the controller states OPA, OPB and EXE and has its result registered
// in FIN; a request that touches memory also steps through MEM, one byte of its
// 1, 2 or 4 at a time since the memory has one byte port, and mult/div waits in
// MD for the one-bit-per-cycle multiply/divide unit. The input is free again as
// soon as the result is registered. A finished result waits in the output
// register; a new request is taken once the previous result has moved into it.
module mips1_instruction_executor_unit #(
	parameter int MEM_BYTES = mie_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] instruction,
	input  logic [31:0] address,
	input  logic [31:0] data,
	input  logic [5:0]  reg_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [31:0] pc_after,
	output logic        unimplemented,
	output logic        halted
);
	import mie_pkg::*;

	mie_cmd_t cmd;
	mie_sts_t sts;

	mie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mie_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.instruction   (instruction),
		.address       (address),
		.data          (data),
		.reg_index     (reg_index),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.read_data     (read_data),
		.pc_after      (pc_after),
		.unimplemented (unimplemented),
		.halted        (halted)
	);

	// an accepted request keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a request");

	// halted flag agrees with the reported pc
	a_halt_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (halted == (pc_after == 32'd0)))
		else $error("halted flag does not match pc_after");

	// a new result only appears after a request was taken
	a_result_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in progress");

endmodule
